// ===== design/ahp_pkg.sv =====
// ----------------------------------------------------------------------------
// ahp_pkg
// Shared types and codes for the AX.25 address header parser: the input
// beat, the decoded result and the field kind codes.
// ----------------------------------------------------------------------------
package ahp_pkg;

  localparam int CALL_W = 48;

  // Field kind codes carried on the result
  localparam logic [2:0] KIND_DEST = 3'd0;
  localparam logic [2:0] KIND_SRC  = 3'd1;
  localparam logic [2:0] KIND_DIGI = 3'd2;
  localparam logic [2:0] KIND_CTRL = 3'd3;
  localparam logic [2:0] KIND_PID  = 3'd4;

  // Address layout: six callsign bytes, then the SSID byte
  localparam logic [2:0] CALL_BYTES = 3'd6;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  typedef struct packed {
    logic       frame_start;
    logic [7:0] data_byte;
  } ahp_beat_t;

  typedef struct packed {
    logic [2:0]        field_kind;
    logic [2:0]        digi_index;
    logic [CALL_W-1:0] callsign;
    logic [3:0]        ssid;
    logic              repeated_bit;
    logic              last_address;
    logic [7:0]        byte_value;
    logic [2:0]        digi_count;
  } ahp_result_t;

endpackage

// ===== design/ahp_in_stage.sv =====
// ----------------------------------------------------------------------------
// ahp_in_stage
// Input register: captures one beat whenever the slot is empty or the held
// beat is consumed in the same cycle.
// ----------------------------------------------------------------------------
module ahp_in_stage
  import ahp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  ahp_beat_t in_beat,
  input  logic      consume,
  output logic      in_stall,
  output logic      beat_vld,
  output ahp_beat_t beat
);

  logic      vld_r;
  ahp_beat_t beat_r;
  logic      load;

  assign load     = !vld_r || consume;
  assign in_stall = !load;
  assign beat_vld = vld_r;
  assign beat     = beat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      beat_r <= in_beat;
    end
  end

endmodule

// ===== design/ahp_parse.sv =====
// ----------------------------------------------------------------------------
// ahp_parse
// Parse state and the one-byte decode step: callsign assembly, SSID byte
// split, control and protocol id capture, digipeater counting.
// ----------------------------------------------------------------------------
module ahp_parse
  import ahp_pkg::*;
#(
  parameter int MAX_DIGIS = 7
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  ahp_beat_t   beat,
  output logic        res_hit,
  output ahp_result_t res
);

  localparam int DS_W = $clog2(MAX_DIGIS + 1);
  localparam logic [DS_W-1:0] DS_MAX = DS_W'(MAX_DIGIS);

  typedef enum logic [6:0] {
    PH_IDLE = 7'b0000001,
    PH_DEST = 7'b0000010,
    PH_SRC  = 7'b0000100,
    PH_DIGI = 7'b0001000,
    PH_CTRL = 7'b0010000,
    PH_PID  = 7'b0100000,
    PH_DONE = 7'b1000000
  } phase_t;

  phase_t            phase_r, phase_nxt, ph;
  logic [2:0]        bia_r, bia_nxt, bia;
  logic [2:0]        ck_r, ck_nxt, ck;
  logic [CALL_W-1:0] cs_r, cs_nxt, cs;
  logic [DS_W-1:0]   ds_r, ds_nxt, ds, ds_inc;
  logic [7:0]        ch;

  always_comb begin
    ph  = phase_r;
    bia = bia_r;
    ck  = ck_r;
    cs  = cs_r;
    ds  = ds_r;
    // frame start restarts the parse at the destination address
    if (beat.frame_start) begin
      ph  = PH_DEST;
      bia = '0;
      ck  = '0;
      cs  = '0;
      ds  = '0;
    end

    ch     = {1'b0, beat.data_byte[7:1]};
    ds_inc = (ds < DS_MAX) ? ds + 1'b1 : ds;

    phase_nxt = ph;
    bia_nxt   = bia;
    ck_nxt    = ck;
    cs_nxt    = cs;
    ds_nxt    = ds;
    res_hit   = 1'b0;
    res       = '0;

    unique case (ph)
      PH_DEST, PH_SRC, PH_DIGI: begin
        if (bia < CALL_BYTES) begin
          // callsign byte: keep unless it is a space
          if (ch != CHAR_SPACE && ck < CALL_BYTES) begin
            for (int i = 0; i < 6; i++) begin
              if (ck == 3'(i)) begin
                cs_nxt[CALL_W-1-8*i -: 8] = cs[CALL_W-1-8*i -: 8] | ch;
              end
            end
            ck_nxt = ck + 3'd1;
          end
          bia_nxt = bia + 3'd1;
        end else begin
          // SSID byte closes the address
          res_hit          = 1'b1;
          res.callsign     = cs;
          res.ssid         = beat.data_byte[4:1];
          res.repeated_bit = beat.data_byte[7];
          res.last_address = beat.data_byte[0];
          bia_nxt          = '0;
          ck_nxt           = '0;
          cs_nxt           = '0;
          priority case (ph)
            PH_DEST: begin
              res.field_kind = KIND_DEST;
              phase_nxt      = PH_SRC;
            end
            PH_SRC: begin
              res.field_kind = KIND_SRC;
              phase_nxt      = beat.data_byte[0] ? PH_CTRL : PH_DIGI;
            end
            default: begin
              res.field_kind = KIND_DIGI;
              res.digi_index = 3'(ds);
              ds_nxt         = ds_inc;
              if (beat.data_byte[0] || ds_inc >= DS_MAX) begin
                phase_nxt = PH_CTRL;
              end
            end
          endcase
        end
      end
      PH_CTRL: begin
        res_hit        = 1'b1;
        res.field_kind = KIND_CTRL;
        res.byte_value = beat.data_byte;
        phase_nxt      = PH_PID;
      end
      PH_PID: begin
        res_hit        = 1'b1;
        res.field_kind = KIND_PID;
        res.byte_value = beat.data_byte;
        res.digi_count = (32'(ds) > 32'd7) ? 3'd7 : 3'(ds);
        phase_nxt      = PH_DONE;
      end
      default: begin
        // idle or done: drop the byte
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      bia_r   <= '0;
      ck_r    <= '0;
      cs_r    <= '0;
      ds_r    <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      bia_r   <= bia_nxt;
      ck_r    <= ck_nxt;
      cs_r    <= cs_nxt;
      ds_r    <= ds_nxt;
    end
  end

endmodule

// ===== design/ahp_out_stage.sv =====
// ----------------------------------------------------------------------------
// ahp_out_stage
// Result register: holds one decoded result until the sink takes it.
// ----------------------------------------------------------------------------
module ahp_out_stage
  import ahp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  logic        res_hit,
  input  ahp_result_t res,
  input  logic        out_stall,
  output logic        slot_free,
  output logic        out_valid,
  output ahp_result_t out_res
);

  logic        vld_r;
  ahp_result_t res_r;

  assign slot_free = !vld_r || !out_stall;
  assign out_valid = vld_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (fire) begin
      vld_r <= res_hit;
    end else if (!out_stall) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_hit) begin
      res_r <= res;
    end
  end

endmodule

// ===== design/ax25_address_header_parser.sv =====
// ----------------------------------------------------------------------------
// ax25_address_header_parser
// Decodes the address header of AX.25 frames from a byte stream.
// ----------------------------------------------------------------------------
// The block takes one frame byte per beat, flagged with in_frame_start on the
// first byte of each frame, and reports the destination, source and up to
// MAX_DIGIS digipeater addresses (callsign with spaces dropped, SSID, H bit
// and last-address bit), then the control byte, then the protocol id byte
// together with the digipeater count. Callsign bytes yield no result; payload
// bytes after the protocol id are dropped until the next frame start. A byte
// passes an input register, combinational decode logic and a result register,
// which drives out_valid and the result ports; one new byte is
// accepted every cycle as long as the result register drains. in_stall rises
// only when a byte waits in the input register while the result register is
// full and stalled.
// ----------------------------------------------------------------------------
module ax25_address_header_parser
  import ahp_pkg::*;
#(
  parameter int MAX_DIGIS = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_frame_start,
  input  logic [7:0]        in_data_byte,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        out_field_kind,
  output logic [2:0]        out_digi_index,
  output logic [CALL_W-1:0] out_callsign,
  output logic [3:0]        out_ssid,
  output logic              out_repeated_bit,
  output logic              out_last_address,
  output logic [7:0]        out_byte_value,
  output logic [2:0]        out_digi_count
);

  ahp_beat_t   in_beat;
  ahp_beat_t   beat;
  logic        beat_vld;
  logic        slot_free;
  logic        fire;
  logic        res_hit;
  ahp_result_t res;
  ahp_result_t out_res;

  assign in_beat.frame_start = in_frame_start;
  assign in_beat.data_byte   = in_data_byte;

  // advance the held beat whenever the result slot can take its outcome
  assign fire = beat_vld && slot_free;

  ahp_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_beat  (in_beat),
    .consume  (fire),
    .in_stall (in_stall),
    .beat_vld (beat_vld),
    .beat     (beat)
  );

  ahp_parse #(
    .MAX_DIGIS (MAX_DIGIS)
  ) u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .beat    (beat),
    .res_hit (res_hit),
    .res     (res)
  );

  ahp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .res_hit   (res_hit),
    .res       (res),
    .out_stall (out_stall),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  // unpack the result onto its ports
  assign out_field_kind   = out_res.field_kind;
  assign out_digi_index   = out_res.digi_index;
  assign out_callsign     = out_res.callsign;
  assign out_ssid         = out_res.ssid;
  assign out_repeated_bit = out_res.repeated_bit;
  assign out_last_address = out_res.last_address;
  assign out_byte_value   = out_res.byte_value;
  assign out_digi_count   = out_res.digi_count;

endmodule
